@@ design/clef_pkg.sv @@
package clef_pkg;

  localparam int DATA_WIDTH     = 32;
  localparam int FRAC_BITS      = 16;
  localparam int DIFF_W         = DATA_WIDTH + 1;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic                         kind;
    logic signed [DATA_WIDTH-1:0] pos_x;
    logic signed [DATA_WIDTH-1:0] pos_y;
    logic signed [DATA_WIDTH-1:0] ref_x;
    logic signed [DATA_WIDTH-1:0] ref_y;
    logic signed [DATA_WIDTH-1:0] tangent_x;
    logic signed [DATA_WIDTH-1:0] tangent_y;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] cont_err;
    logic signed [DATA_WIDTH-1:0] lag_err;
  } out_item_t;

  // one position item after the reference is subtracted, with its tangent
  typedef struct packed {
    logic signed [DIFF_W-1:0]     ex;
    logic signed [DIFF_W-1:0]     ey;
    logic signed [DATA_WIDTH-1:0] tx;
    logic signed [DATA_WIDTH-1:0] ty;
  } job_t;

  localparam logic KIND_REF = 1'b0;
  localparam logic KIND_POS = 1'b1;

endpackage

@@ design/clef_front.sv @@
module clef_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  clef_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output clef_pkg::job_t    push_data
);
  import clef_pkg::*;

  logic signed [DATA_WIDTH-1:0] ref_x_r, ref_x_nxt;
  logic signed [DATA_WIDTH-1:0] ref_y_r, ref_y_nxt;
  logic signed [DATA_WIDTH-1:0] tan_x_r, tan_x_nxt;
  logic signed [DATA_WIDTH-1:0] tan_y_r, tan_y_nxt;
  logic                         xfer;

  assign in_ready   = push_ready;
  assign xfer       = in_valid && in_ready;
  assign push_valid = in_valid && (in_data.kind == KIND_POS);

  assign push_data.ex = {in_data.pos_x[DATA_WIDTH-1], in_data.pos_x}
                      - {ref_x_r[DATA_WIDTH-1], ref_x_r};
  assign push_data.ey = {in_data.pos_y[DATA_WIDTH-1], in_data.pos_y}
                      - {ref_y_r[DATA_WIDTH-1], ref_y_r};
  assign push_data.tx = tan_x_r;
  assign push_data.ty = tan_y_r;

  always_comb begin
    ref_x_nxt = ref_x_r;
    ref_y_nxt = ref_y_r;
    tan_x_nxt = tan_x_r;
    tan_y_nxt = tan_y_r;
    if (xfer && (in_data.kind == KIND_REF)) begin
      ref_x_nxt = in_data.ref_x;
      ref_y_nxt = in_data.ref_y;
      tan_x_nxt = in_data.tangent_x;
      tan_y_nxt = in_data.tangent_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r <= '0;
      ref_y_r <= '0;
      tan_x_r <= DATA_WIDTH'(1) << FRAC_BITS;
      tan_y_r <= '0;
    end else begin
      ref_x_r <= ref_x_nxt;
      ref_y_r <= ref_y_nxt;
      tan_x_r <= tan_x_nxt;
      tan_y_r <= tan_y_nxt;
    end
  end

endmodule

@@ design/clef_queue.sv @@
module clef_queue #(
  parameter int DEPTH = clef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  clef_pkg::job_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output clef_pkg::job_t pop_data
);
  import clef_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/clef_back.sv @@
module clef_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  clef_pkg::job_t     pop_data,
  output logic               out_valid,
  input  logic               out_ready,
  output clef_pkg::out_item_t out_data
);
  import clef_pkg::*;

  localparam int NORM_LOW_BIT = 45;
  localparam int NORM_COARSE  = 8;
  localparam int TAN_W        = (DATA_WIDTH + 2 > NORM_LOW_BIT + 4) ?
                                DATA_WIDTH + 2 : NORM_LOW_BIT + 4;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int GUARD_BITS   = 4;
  localparam int ERR_W        = DIFF_W + GUARD_BITS + 3;
  localparam int GAIN_BITS    = 24;
  localparam logic [GAIN_BITS-1:0] INV_GAIN = 24'd10188014;
  localparam int MUL_CHUNK    = 16;
  localparam int MUL_CHUNKS   = (ERR_W + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int EXT_W        = MUL_CHUNKS * MUL_CHUNK;
  localparam int PROD_W       = MUL_CHUNK + GAIN_BITS + 2;
  localparam int ACC_W        = EXT_W + GAIN_BITS + 1;
  localparam int ROUND_SHIFT  = GAIN_BITS + GUARD_BITS;
  localparam int SAT_W        = ACC_W - ROUND_SHIFT + 1;
  localparam int CH_W         = (MUL_CHUNKS > 1) ? $clog2(MUL_CHUNKS) : 1;

  localparam logic [TAN_W-1:0] M_COARSE = TAN_W'(1) << (NORM_LOW_BIT - NORM_COARSE);
  localparam logic [TAN_W-1:0] M_LOW    = TAN_W'(1) << NORM_LOW_BIT;
  localparam logic [TAN_W-1:0] M_HIGH   = TAN_W'(1) << (NORM_LOW_BIT + 1);
  localparam logic [ACC_W-1:0] ROUND_C  = ACC_W'(1) << (ROUND_SHIFT - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_NORM = 6'b000010,
    ST_ROT  = 6'b000100,
    ST_GAIN = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  function automatic logic [DATA_WIDTH-1:0] sat_data(input logic signed [SAT_W-1:0] v);
    logic [DATA_WIDTH-1:0] res;
    if ((&v[SAT_W-1:DATA_WIDTH-1]) || !(|v[SAT_W-1:DATA_WIDTH-1])) begin
      res = v[DATA_WIDTH-1:0];
    end else if (v[SAT_W-1]) begin
      res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

  state_t                   state_r, state_nxt;
  logic signed [TAN_W-1:0]  tx_r, tx_nxt;
  logic signed [TAN_W-1:0]  ty_r, ty_nxt;
  logic        [TAN_W-1:0]  m_r, m_nxt;
  logic signed [ERR_W-1:0]  ex_r, ex_nxt;
  logic signed [ERR_W-1:0]  ey_r, ey_nxt;
  logic        [STEP_W-1:0] step_r, step_nxt;
  logic        [CH_W-1:0]   chunk_r, chunk_nxt;
  logic signed [ACC_W-1:0]  acc_x_r, acc_x_nxt;
  logic signed [ACC_W-1:0]  acc_y_r, acc_y_nxt;
  logic [DATA_WIDTH-1:0]    con_r, con_nxt;
  logic [DATA_WIDTH-1:0]    lag_r, lag_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  // job load
  logic                     tneg;
  logic signed [TAN_W-1:0]  tx_e, ty_e, tx_n, ty_n, ty_abs;
  logic signed [ERR_W-1:0]  ex_e, ey_e;
  logic signed [SAT_W-1:0]  exb, eyb;

  // gain compensation
  logic signed [EXT_W-1:0]  ex_ext, ey_ext;
  logic        [MUL_CHUNK-1:0] chx, chy;
  logic                     top_chunk;
  logic signed [MUL_CHUNK:0]   chx_s, chy_s;
  logic signed [GAIN_BITS:0]   gain_s;
  logic signed [PROD_W-1:0]    prod_x, prod_y;
  logic        [ACC_W-1:0]     base_x, base_y;
  logic        [ACC_W-1:0]     sum_x, sum_y;
  logic signed [SAT_W-1:0]     rx, ry;

  assign tneg   = pop_data.tx[DATA_WIDTH-1];
  assign tx_e   = {{(TAN_W-DATA_WIDTH){pop_data.tx[DATA_WIDTH-1]}}, pop_data.tx};
  assign ty_e   = {{(TAN_W-DATA_WIDTH){pop_data.ty[DATA_WIDTH-1]}}, pop_data.ty};
  assign tx_n   = tneg ? -tx_e : tx_e;
  assign ty_n   = tneg ? -ty_e : ty_e;
  assign ty_abs = ty_n[TAN_W-1] ? -ty_n : ty_n;
  assign ex_e   = {{(ERR_W-DIFF_W-GUARD_BITS){pop_data.ex[DIFF_W-1]}}, pop_data.ex,
                   {GUARD_BITS{1'b0}}};
  assign ey_e   = {{(ERR_W-DIFF_W-GUARD_BITS){pop_data.ey[DIFF_W-1]}}, pop_data.ey,
                   {GUARD_BITS{1'b0}}};
  assign exb    = {{(SAT_W-DIFF_W){pop_data.ex[DIFF_W-1]}}, pop_data.ex};
  assign eyb    = {{(SAT_W-DIFF_W){pop_data.ey[DIFF_W-1]}}, pop_data.ey};

  assign ex_ext    = {{(EXT_W-ERR_W){ex_r[ERR_W-1]}}, ex_r};
  assign ey_ext    = {{(EXT_W-ERR_W){ey_r[ERR_W-1]}}, ey_r};
  assign chx       = ex_ext[chunk_r*MUL_CHUNK +: MUL_CHUNK];
  assign chy       = ey_ext[chunk_r*MUL_CHUNK +: MUL_CHUNK];
  assign top_chunk = (chunk_r == CH_W'(MUL_CHUNKS - 1));
  assign chx_s     = {top_chunk & chx[MUL_CHUNK-1], chx};
  assign chy_s     = {top_chunk & chy[MUL_CHUNK-1], chy};
  assign gain_s    = {1'b0, INV_GAIN};
  assign prod_x    = chx_s * gain_s;
  assign prod_y    = chy_s * gain_s;
  assign base_x    = top_chunk ? '0 : {acc_x_r[ACC_W-1-MUL_CHUNK:0], {MUL_CHUNK{1'b0}}};
  assign base_y    = top_chunk ? '0 : {acc_y_r[ACC_W-1-MUL_CHUNK:0], {MUL_CHUNK{1'b0}}};

  assign sum_x = acc_x_r + ROUND_C;
  assign sum_y = acc_y_r + ROUND_C;
  assign rx    = {sum_x[ACC_W-1], sum_x[ACC_W-1:ROUND_SHIFT]};
  assign ry    = {sum_y[ACC_W-1], sum_y[ACC_W-1:ROUND_SHIFT]};

  assign pop_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    m_nxt         = m_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    step_nxt      = step_r;
    chunk_nxt     = chunk_r;
    acc_x_nxt     = acc_x_r;
    acc_y_nxt     = acc_y_r;
    con_nxt       = con_r;
    lag_nxt       = lag_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          if (pop_data.ty == '0) begin
            // tangent on the x axis: phi is zero or pi
            con_nxt   = sat_data(tneg ? eyb : -eyb);
            lag_nxt   = sat_data(tneg ? exb : -exb);
            state_nxt = ST_OUT;
          end else begin
            tx_nxt    = tx_n;
            ty_nxt    = ty_n;
            m_nxt     = ($unsigned(tx_n) > $unsigned(ty_abs)) ? tx_n : ty_abs;
            ex_nxt    = tneg ? -ex_e : ex_e;
            ey_nxt    = tneg ? -ey_e : ey_e;
            state_nxt = ST_NORM;
          end
        end
      end
      ST_NORM: begin
        if (m_r < M_COARSE) begin
          m_nxt  = m_r << NORM_COARSE;
          tx_nxt = tx_r <<< NORM_COARSE;
          ty_nxt = ty_r <<< NORM_COARSE;
        end else if (m_r < M_LOW) begin
          m_nxt  = m_r << 1;
          tx_nxt = tx_r <<< 1;
          ty_nxt = ty_r <<< 1;
        end else if (m_r >= M_HIGH) begin
          m_nxt  = m_r >> 1;
          tx_nxt = tx_r >>> 1;
          ty_nxt = ty_r >>> 1;
        end else begin
          step_nxt  = '0;
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (!ty_r[TAN_W-1]) begin
          tx_nxt = tx_r + (ty_r >>> step_r);
          ty_nxt = ty_r - (tx_r >>> step_r);
          ex_nxt = ex_r + (ey_r >>> step_r);
          ey_nxt = ey_r - (ex_r >>> step_r);
        end else begin
          tx_nxt = tx_r - (ty_r >>> step_r);
          ty_nxt = ty_r + (tx_r >>> step_r);
          ex_nxt = ex_r - (ey_r >>> step_r);
          ey_nxt = ey_r + (ex_r >>> step_r);
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          chunk_nxt = CH_W'(MUL_CHUNKS - 1);
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        // top chunk first, then shift and add the lower ones
        acc_x_nxt = base_x + {{(ACC_W-PROD_W){prod_x[PROD_W-1]}}, prod_x};
        acc_y_nxt = base_y + {{(ACC_W-PROD_W){prod_y[PROD_W-1]}}, prod_y};
        chunk_nxt = chunk_r - CH_W'(1);
        if (chunk_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        con_nxt   = sat_data(-ry);
        lag_nxt   = sat_data(-rx);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.cont_err = con_r;
          out_data_nxt.lag_err  = lag_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    m_r        <= m_nxt;
    ex_r       <= ex_nxt;
    ey_r       <= ey_nxt;
    step_r     <= step_nxt;
    chunk_r    <= chunk_nxt;
    acc_x_r    <= acc_x_nxt;
    acc_y_r    <= acc_y_nxt;
    con_r      <= con_nxt;
    lag_r      <= lag_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ design/contouring_lag_error_unit.sv @@
// channel   ports                            payload
// input     in_valid, in_ready, in_data      clef_pkg::in_item_t
// result    out_valid, out_ready, out_data   clef_pkg::out_item_t
//
// a reference item updates the stored point and tangent in the cycle it is taken
// a position item on an axis tangent skips the rotation, else it passes through the
// back end in steps: up to 13 normalize steps, 16 cordic steps, 3 gain multiply steps
// the job queue and the output register let input transfers go on while a result waits
// synchronous active low reset

module contouring_lag_error_unit #(
  parameter int QUEUE_DEPTH = clef_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clef_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clef_pkg::out_item_t out_data
);
  import clef_pkg::*;

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  job_t push_data, pop_data;

  clef_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  clef_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  clef_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sim/tb_contouring_lag_error_unit.sv @@
`timescale 1ns / 100ps

module tb_contouring_lag_error_unit;
  import clef_pkg::*;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  localparam int     CLK_PERIOD  = 20;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     DRAIN_CYCLES = 60;
  localparam int     CORDIC_STEPS = 16;
  localparam longint GUARD_SCALE = 16;
  localparam longint INV_GAIN    = 10188014;
  localparam longint NORM_LOW    = longint'(1) <<< 45;
  localparam longint WORD_MAX    = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
  localparam longint WORD_MIN    = -WORD_MAX - 1;
  localparam word_t  ONE         = word_t'(longint'(1) <<< FRAC_BITS);
  localparam word_t  MAX_W       = word_t'(WORD_MAX);
  localparam word_t  MIN_W       = word_t'(WORD_MIN);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  longint    path_ref_x;
  longint    path_ref_y;
  longint    path_tan_x;
  longint    path_tan_y;
  out_item_t expected_errors[$];

  int        mismatch_count;
  int        cycle_count;
  int        sender_idle_pct;
  int        receiver_idle_pct;
  int        stall_cycles_left;

  contouring_lag_error_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic word_t saturate_word(longint v);
    if (v > WORD_MAX) return MAX_W;
    if (v < WORD_MIN) return MIN_W;
    return word_t'(v);
  endfunction

  // 1/K for 16 steps with the guard bits removed, rounded half up
  function automatic longint compensate_gain(longint v);
    longint hi, lo;
    hi = v >>> 16;
    lo = v - hi * 65536;
    return (hi * INV_GAIN + ((lo * INV_GAIN) >>> 16) + 2048) >>> 12;
  endfunction

  function automatic out_item_t rotate_into_path(longint ex, longint ey,
                                                 longint tx, longint ty);
    longint    m, ntx, nty, nex, ney, lag, con;
    out_item_t r;
    if (ty == 0) begin
      lag = (tx < 0) ? ex : -ex;
      con = (tx < 0) ? ey : -ey;
    end else begin
      ex = ex * GUARD_SCALE;
      ey = ey * GUARD_SCALE;
      if (tx < 0) begin
        tx = -tx;
        ty = -ty;
        ex = -ex;
        ey = -ey;
      end
      m = (ty < 0) ? -ty : ty;
      if (tx > m) m = tx;
      while (m < NORM_LOW) begin
        m = m * 2;
        tx = tx * 2;
        ty = ty * 2;
      end
      while (m >= 2 * NORM_LOW) begin
        m = m >>> 1;
        tx = tx >>> 1;
        ty = ty >>> 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        if (ty >= 0) begin
          ntx = tx + (ty >>> i);
          nty = ty - (tx >>> i);
          nex = ex + (ey >>> i);
          ney = ey - (ex >>> i);
        end else begin
          ntx = tx - (ty >>> i);
          nty = ty + (tx >>> i);
          nex = ex - (ey >>> i);
          ney = ey + (ex >>> i);
        end
        tx = ntx;
        ty = nty;
        ex = nex;
        ey = ney;
      end
      lag = -compensate_gain(ex);
      con = -compensate_gain(ey);
    end
    r.cont_err = saturate_word(con);
    r.lag_err  = saturate_word(lag);
    return r;
  endfunction

  task automatic predict_transfer(input in_item_t item);
    if (item.kind == KIND_REF) begin
      path_ref_x = longint'($signed(item.ref_x));
      path_ref_y = longint'($signed(item.ref_y));
      path_tan_x = longint'($signed(item.tangent_x));
      path_tan_y = longint'($signed(item.tangent_y));
    end else begin
      expected_errors.push_back(rotate_into_path(
        longint'($signed(item.pos_x)) - path_ref_x,
        longint'($signed(item.pos_y)) - path_ref_y,
        path_tan_x, path_tan_y));
    end
  endtask

  function automatic in_item_t ref_item(word_t rx, word_t ry, word_t tx, word_t ty);
    in_item_t it;
    it.kind      = KIND_REF;
    it.pos_x     = word_t'($urandom);
    it.pos_y     = word_t'($urandom);
    it.ref_x     = rx;
    it.ref_y     = ry;
    it.tangent_x = tx;
    it.tangent_y = ty;
    return it;
  endfunction

  function automatic in_item_t pos_item(word_t px, word_t py);
    in_item_t it;
    it.kind      = KIND_POS;
    it.pos_x     = px;
    it.pos_y     = py;
    it.ref_x     = word_t'($urandom);
    it.ref_y     = word_t'($urandom);
    it.tangent_x = word_t'($urandom);
    it.tangent_y = word_t'($urandom);
    return it;
  endfunction

  function automatic word_t random_word();
    int v;
    case ($urandom_range(9))
      5, 6: begin
        v = int'($urandom_range(2097151)) - 1048576;
        return word_t'(v);
      end
      7: begin
        case ($urandom_range(5))
          0: return MAX_W;
          1: return MIN_W;
          2: return word_t'(1);
          3: return word_t'(-1);
          4: return ONE;
          default: return word_t'(0);
        endcase
      end
      8: return word_t'(0);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d",
             what, got, want, cycle_count);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_errors.size() == 0) begin
      report_mismatch("unexpected transfer", got.cont_err, 0);
    end else begin
      want = expected_errors.pop_front();
      if (got.cont_err !== want.cont_err)
        report_mismatch("cont_err", got.cont_err, want.cont_err);
      if (got.lag_err !== want.lag_err)
        report_mismatch("lag_err", got.lag_err, want.lag_err);
    end
  endtask

  task automatic send_item(input in_item_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_transfer(item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // receiver side: check, then decide the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result(out_data);
    if (stall_cycles_left > 0) begin
      stall_cycles_left = stall_cycles_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic test_reset_state();
    send_item(pos_item(word_t'(3 * ONE), word_t'(-2 * ONE)));
    send_item(pos_item(MIN_W, MAX_W));
    send_item(pos_item(MAX_W, MIN_W));
  endtask

  task automatic test_axis_tangents();
    // negative x axis, then zero tangent, then positive x axis
    send_item(ref_item(word_t'(ONE + ONE / 2), word_t'(-ONE / 2), word_t'(-ONE), 0));
    send_item(pos_item(word_t'(2 * ONE), ONE));
    send_item(pos_item(MIN_W, MIN_W));
    send_item(ref_item(0, 0, 0, 0));
    send_item(pos_item(MAX_W, word_t'(-ONE)));
    send_item(ref_item(ONE, ONE, word_t'(5 * ONE / 2), 0));
    send_item(pos_item(word_t'(4 * ONE), word_t'(-3 * ONE)));
  endtask

  task automatic test_extreme_tangents();
    send_item(ref_item(MAX_W, MIN_W, MAX_W, MAX_W));
    send_item(pos_item(MIN_W, MAX_W));
    send_item(ref_item(ONE, word_t'(-ONE), MIN_W, MIN_W));
    send_item(pos_item(word_t'(3 * ONE), word_t'(4 * ONE)));
    send_item(ref_item(ONE, word_t'(-ONE), 0, MIN_W));
    send_item(pos_item(word_t'(-5 * ONE), word_t'(7 * ONE)));
    send_item(ref_item(ONE, word_t'(-ONE), 0, MAX_W));
    send_item(pos_item(word_t'(5 * ONE), word_t'(-7 * ONE)));
    send_item(ref_item(0, 0, word_t'(1), word_t'(-1)));
    send_item(pos_item(MAX_W, MAX_W));
    send_item(ref_item(0, 0, MIN_W, word_t'(-1)));
    send_item(pos_item(word_t'(ONE / 3), word_t'(-ONE / 7)));
    send_item(ref_item(MIN_W, MAX_W, word_t'(-1), MAX_W));
    send_item(pos_item(MAX_W, MIN_W));
  endtask

  task automatic test_random_path(input int count);
    word_t tx, ty;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 25) begin
        tx = random_word();
        ty = ($urandom_range(9) == 0) ? word_t'(0) : random_word();
        send_item(ref_item(random_word(), random_word(), tx, ty));
      end else if ($urandom_range(1) == 0) begin
        send_item(pos_item(word_t'(path_ref_x + longint'($signed(random_word()) >>> 6)),
                           word_t'(path_ref_y + longint'($signed(random_word()) >>> 6))));
      end else begin
        send_item(pos_item(random_word(), random_word()));
      end
    end
  endtask

  task automatic test_output_backpressure();
    int saved_pct;
    saved_pct = sender_idle_pct;
    sender_idle_pct = 0;
    stall_cycles_left = 400;
    for (int n = 0; n < 12; n++)
      send_item(pos_item(random_word(), random_word()));
    sender_idle_pct = saved_pct;
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    stall_cycles_left = 0;
    sender_idle_pct = 13;
    receiver_idle_pct = 57;
    path_ref_x = 0;
    path_ref_y = 0;
    path_tan_x = longint'(ONE);
    path_tan_y = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_axis_tangents();
    test_extreme_tangents();
    test_random_path(130);

    sender_idle_pct = 57;
    receiver_idle_pct = 13;
    test_random_path(130);
    test_output_backpressure();

    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    test_random_path(140);
    in_valid <= 1'b0;

    while (expected_errors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_errors.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
